// ----- src/track_bbox_and_climb_stats_assert.svh -----
// Assertion helpers shared by the track statistics modules.
// Both expect clk_i and rst_ni (active low) in the scope of use.
`ifndef TRACK_BBOX_AND_CLIMB_STATS_ASSERT_SVH
`define TRACK_BBOX_AND_CLIMB_STATS_ASSERT_SVH

// Same-cycle implication.
`define TBCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tbcs_pkg.sv -----
package tbcs_pkg;

  localparam int LatW  = 28;
  localparam int LonW  = 29;
  localparam int EleW  = 21;
  localparam int CntW  = 32;
  localparam int TotW  = 32;
  localparam int HystW = 17;

  localparam logic [HystW-1:0] HystReset = 17'd500;

  // Per-point request into the elevation unit
  typedef struct packed {
    logic            new_track;
    logic            ele_valid;
    logic [EleW-1:0] ele_cm;
  } ele_req_t;

  // Elevation statistics after the last accepted point
  typedef struct packed {
    logic            seen;
    logic [EleW-1:0] low;
    logic [EleW-1:0] high;
    logic [TotW-1:0] climb;
    logic [TotW-1:0] descent;
  } ele_stats_t;

endpackage

// ----- src/tbcs_ele.sv -----
`include "track_bbox_and_climb_stats_assert.svh"

module tbcs_ele
  import tbcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ele_req_t         req_i,
  input  logic [HystW-1:0] hyst_i,
  output ele_stats_t       stats_o
);

  logic            seen_q, seen_d;
  logic [EleW-1:0] ref_q, ref_d;
  logic [EleW-1:0] low_q, low_d;
  logic [EleW-1:0] high_q, high_d;
  logic [TotW-1:0] climb_q, climb_d;
  logic [TotW-1:0] descent_q, descent_d;

  // state as seen by this point (new track clears first)
  logic            seen_b;
  logic [EleW-1:0] ref_b, low_b, high_b;
  logic [TotW-1:0] climb_b, descent_b;

  logic [EleW:0]   diff;       // ele - reference, one bit wider
  logic [EleW+1:0] diff_x;
  logic [EleW+1:0] hyst_x;
  logic [EleW+1:0] desc_sum;
  logic [EleW:0]   diff_neg;
  logic            climb_hit, desc_hit;
  logic [TotW:0]   climb_sum, descent_sum;

  always_comb begin
    seen_b    = req_i.new_track ? 1'b0 : seen_q;
    ref_b     = req_i.new_track ? '0 : ref_q;
    low_b     = req_i.new_track ? '0 : low_q;
    high_b    = req_i.new_track ? '0 : high_q;
    climb_b   = req_i.new_track ? '0 : climb_q;
    descent_b = req_i.new_track ? '0 : descent_q;

    diff      = {req_i.ele_cm[EleW-1], req_i.ele_cm} - {ref_b[EleW-1], ref_b};
    diff_x    = {diff[EleW], diff};
    hyst_x    = {{(EleW+2-HystW){1'b0}}, hyst_i};
    climb_hit = $signed(diff_x) >= $signed(hyst_x);
    // diff <= -hyst  <=>  diff + hyst <= 0
    desc_sum  = diff_x + hyst_x;
    desc_hit  = desc_sum[EleW+1] || (desc_sum == '0);
    diff_neg  = '0 - diff;

    climb_sum   = {1'b0, climb_b} + {{(TotW+1-EleW){1'b0}}, diff[EleW-1:0]};
    descent_sum = {1'b0, descent_b} + {{(TotW-EleW){1'b0}}, diff_neg};

    seen_d    = seen_b;
    ref_d     = ref_b;
    low_d     = low_b;
    high_d    = high_b;
    climb_d   = climb_b;
    descent_d = descent_b;

    if (req_i.ele_valid) begin
      if (!seen_b) begin
        // first elevation sets the reference, low and high, and adds no climb or descent
        seen_d = 1'b1;
        ref_d  = req_i.ele_cm;
        low_d  = req_i.ele_cm;
        high_d = req_i.ele_cm;
      end else begin
        if ($signed(req_i.ele_cm) < $signed(low_b))  low_d  = req_i.ele_cm;
        if ($signed(req_i.ele_cm) > $signed(high_b)) high_d = req_i.ele_cm;
        priority if (climb_hit) begin
          climb_d = climb_sum[TotW] ? '1 : climb_sum[TotW-1:0];
          ref_d   = req_i.ele_cm;
        end else if (desc_hit) begin
          descent_d = descent_sum[TotW] ? '1 : descent_sum[TotW-1:0];
          ref_d     = req_i.ele_cm;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      ref_q     <= '0;
      low_q     <= '0;
      high_q    <= '0;
      climb_q   <= '0;
      descent_q <= '0;
    end else if (en_i) begin
      seen_q    <= seen_d;
      ref_q     <= ref_d;
      low_q     <= low_d;
      high_q    <= high_d;
      climb_q   <= climb_d;
      descent_q <= descent_d;
    end
  end

  assign stats_o.seen    = seen_q;
  assign stats_o.low     = low_q;
  assign stats_o.high    = high_q;
  assign stats_o.climb   = climb_q;
  assign stats_o.descent = descent_q;

  `TBCS_ASSERT_IMP(a_ele_order, seen_q, $signed(low_q) <= $signed(high_q),
                   "elevation min above max")
  `TBCS_ASSERT_IMP(a_ele_unseen_zero, !seen_q,
                   (low_q == '0) && (high_q == '0) &&
                   (climb_q == '0) && (descent_q == '0),
                   "elevation stats set before any elevation")
  `TBCS_ASSERT_NXT(a_climb_monotonic, en_i && !req_i.new_track,
                   (climb_q >= $past(climb_q)) && (descent_q >= $past(descent_q)),
                   "climb or descent total decreased within a track")

endmodule

// ----- src/track_bbox_and_climb_stats.sv -----
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   new_track, lat, lon, ele_valid, ele
// out       output     out_valid_o / out_stall_i bbox, point_count, elevation stats
// cfg       input      cfg_valid_i / cfg_ready_o hysteresis_cm (cfg_data_i)
//
// One point per cycle while in_stall_o is low; its result appears in the cycle after acceptance.
// The statistics registers are the result register: one compare/add level per point.
// in_stall_o follows out_stall_i while a result is held; cfg is always ready.
// Reset clears all statistics and loads the hysteresis threshold with 500 cm.
`include "track_bbox_and_climb_stats_assert.svh"

module track_bbox_and_climb_stats
  import tbcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             new_track_i,
  input  logic [LatW-1:0]  lat_udeg_i,
  input  logic [LonW-1:0]  lon_udeg_i,
  input  logic             ele_valid_i,
  input  logic [EleW-1:0]  ele_cm_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LatW-1:0]  min_lat_udeg_o,
  output logic [LatW-1:0]  max_lat_udeg_o,
  output logic [LonW-1:0]  min_lon_udeg_o,
  output logic [LonW-1:0]  max_lon_udeg_o,
  output logic [CntW-1:0]  point_count_o,
  output logic             has_elevation_o,
  output logic [EleW-1:0]  min_ele_cm_o,
  output logic [EleW-1:0]  max_ele_cm_o,
  output logic [TotW-1:0]  climb_cm_o,
  output logic [TotW-1:0]  descent_cm_o,

  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [HystW-1:0] cfg_data_i
);

  logic             in_acc;
  logic             out_valid_q;
  logic [HystW-1:0] hyst_q;

  logic [CntW-1:0]  count_q, count_d, cnt_b;
  logic [LatW-1:0]  lat_lo_q, lat_lo_d, lat_hi_q, lat_hi_d;
  logic [LonW-1:0]  lon_lo_q, lon_lo_d, lon_hi_q, lon_hi_d;
  logic [LatW-1:0]  lat_lo_b, lat_hi_b;
  logic [LonW-1:0]  lon_lo_b, lon_hi_b;
  logic             first_pt;

  ele_req_t         ele_req;
  ele_stats_t       ele_stats;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= HystReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hyst_q <= cfg_data_i;
    end
  end

  always_comb begin
    cnt_b    = new_track_i ? '0 : count_q;
    first_pt = (cnt_b == '0);
    // first point of a track seeds the box
    lat_lo_b = first_pt ? lat_udeg_i : lat_lo_q;
    lat_hi_b = first_pt ? lat_udeg_i : lat_hi_q;
    lon_lo_b = first_pt ? lon_udeg_i : lon_lo_q;
    lon_hi_b = first_pt ? lon_udeg_i : lon_hi_q;

    lat_lo_d = ($signed(lat_udeg_i) < $signed(lat_lo_b)) ? lat_udeg_i : lat_lo_b;
    lat_hi_d = ($signed(lat_udeg_i) > $signed(lat_hi_b)) ? lat_udeg_i : lat_hi_b;
    lon_lo_d = ($signed(lon_udeg_i) < $signed(lon_lo_b)) ? lon_udeg_i : lon_lo_b;
    lon_hi_d = ($signed(lon_udeg_i) > $signed(lon_hi_b)) ? lon_udeg_i : lon_hi_b;

    count_d  = (&cnt_b) ? cnt_b : cnt_b + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lat_lo_q <= '0;
      lat_hi_q <= '0;
      lon_lo_q <= '0;
      lon_hi_q <= '0;
    end else if (in_acc) begin
      count_q  <= count_d;
      lat_lo_q <= lat_lo_d;
      lat_hi_q <= lat_hi_d;
      lon_lo_q <= lon_lo_d;
      lon_hi_q <= lon_hi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc || (out_valid_q && out_stall_i);
    end
  end

  assign ele_req.new_track = new_track_i;
  assign ele_req.ele_valid = ele_valid_i;
  assign ele_req.ele_cm    = ele_cm_i;

  tbcs_ele u_ele (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .req_i   (ele_req),
    .hyst_i  (hyst_q),
    .stats_o (ele_stats)
  );

  assign out_valid_o     = out_valid_q;
  assign min_lat_udeg_o  = lat_lo_q;
  assign max_lat_udeg_o  = lat_hi_q;
  assign min_lon_udeg_o  = lon_lo_q;
  assign max_lon_udeg_o  = lon_hi_q;
  assign point_count_o   = count_q;
  assign has_elevation_o = ele_stats.seen;
  assign min_ele_cm_o    = ele_stats.low;
  assign max_ele_cm_o    = ele_stats.high;
  assign climb_cm_o      = ele_stats.climb;
  assign descent_cm_o    = ele_stats.descent;

  `TBCS_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_q,
                   "accepted request produced no result")
  `TBCS_ASSERT_NXT(a_new_track_count, in_acc && new_track_i, count_q == 32'd1,
                   "new track did not restart point count")
  `TBCS_ASSERT_IMP(a_bbox_order, count_q != '0,
                   ($signed(lat_lo_q) <= $signed(lat_hi_q)) &&
                   ($signed(lon_lo_q) <= $signed(lon_hi_q)),
                   "bounding box inverted")
  `TBCS_ASSERT_NXT(a_stats_hold, !in_acc, $stable(count_q) && $stable(lat_lo_q),
                   "statistics changed without a request")

endmodule
